// ===== src/segregated_free_list_allocator_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define SFLA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator check failed");

// Next-cycle implication checked at every rising clock edge outside reset.
`define SFLA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

// ===== src/sfla_pkg.sv =====
// Types and constants of the segregated free-list allocator.
package sfla_pkg;

   localparam int ADDR_BITS    = 16;
   localparam int NUM_CLASSES  = 16;
   localparam int GRANULE      = 8;
   localparam int REFILL_COUNT = 20;
   localparam int GRAN_SHIFT   = $clog2(GRANULE);
   localparam int CLS_BITS     = $clog2(NUM_CLASSES);
   localparam int SLOT_BITS    = ADDR_BITS - GRAN_SHIFT;
   localparam int LINK_DEPTH   = 1 << SLOT_BITS;
   localparam int WIDE_BITS    = ADDR_BITS + 1;
   localparam int CNT_BITS     = $clog2(REFILL_COUNT + 1);
   localparam int TRY_LIMIT    = 3;

   localparam logic [WIDE_BITS-1:0] ADDR_SPACE  = WIDE_BITS'(1) << ADDR_BITS;
   localparam logic [WIDE_BITS-1:0] MAX_SMALL   = WIDE_BITS'(NUM_CLASSES * GRANULE);
   localparam logic [WIDE_BITS-1:0] LIMIT_RESET = WIDE_BITS'(65536);
   localparam logic [WIDE_BITS-1:0] TOP_RESET   = WIDE_BITS'(GRANULE);

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic [2:0] REG_HEAP_LIMIT = 3'd0;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FORWARDED = 2'd1,
      STATUS_NO_MEMORY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP_WAIT,
      ST_TRY,
      ST_SCAN,
      ST_SCAN_POP,
      ST_LINK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] slot;
      logic [ADDR_BITS-1:0] data;
   } link_wr_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] slot;
   } link_rd_type;

endpackage

// ===== src/segregated_free_list_allocator.sv =====
// Segregated free-list allocator: 16 size classes of 8 bytes, pool refill and scavenging.
// One transaction is handled at a time. A release, a forwarded request or an allocate
// that finds its class list non-empty is decoded and answered; the allocate first waits
// on the link read of the popped head. An allocate that refills writes one link per
// refilled block beyond the first (up to 19 link writes). Growing the pool from the heap
// first adds a pass through the try step. A scavenge scans the size classes in turn
// (up to 16), pops one block and makes a further pass through the refill. The link
// store is a single-port-write, single-port-read memory of 8192 entries whose read
// data is registered.
// A new request is taken while a finished response still waits on rsp_tready.
module segregated_free_list_allocator
   import sfla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // size[11:0], address[27:12], zeros above
   input  logic        req_tuser,   // kind[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // block_address[15:0], status[17:16], zeros above
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   `include "segregated_free_list_allocator_macros.svh"

   state_type state_ff, state_in;

   logic                 kind_ff, kind_in;
   logic [11:0]          size_ff, size_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [WIDE_BITS-1:0] pool_start_ff, pool_start_in;
   logic [WIDE_BITS-1:0] pool_end_ff, pool_end_in;
   logic [WIDE_BITS-1:0] heap_top_ff, heap_top_in;
   logic [WIDE_BITS-1:0] heap_grown_ff, heap_grown_in;
   logic [WIDE_BITS-1:0] heap_limit_ff, heap_limit_in;
   logic [1:0]           tries_ff, tries_in;
   logic [CLS_BITS-1:0]  scan_ff, scan_in;
   logic [WIDE_BITS-1:0] cur_ff, cur_in;
   logic [WIDE_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [ADDR_BITS-1:0] blk_ff, blk_in;
   status_type           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic [ADDR_BITS-1:0] heads_ff [NUM_CLASSES];
   logic                 head_we;
   logic [CLS_BITS-1:0]  head_widx;
   logic [ADDR_BITS-1:0] head_wdata;
   logic [CLS_BITS-1:0]  head_ridx;
   logic [ADDR_BITS-1:0] head_rdata;

   link_wr_type          link_wr;
   link_rd_type          link_rd;
   logic [ADDR_BITS-1:0] link_rdata;

   logic                 req_accept;
   logic                 cfg_write;
   logic [CLS_BITS-1:0]  cls;
   logic [WIDE_BITS-1:0] bytes;
   logic [WIDE_BITS-1:0] left;
   logic [WIDE_BITS-1:0] need;
   logic [WIDE_BITS-1:0] grow;
   logic [WIDE_BITS-1:0] limit;
   logic [CLS_BITS-1:0]  left_cls;
   logic [WIDE_BITS-1:0] next_addr;
   logic                 last_block;

   sfla_link_store u_link_store (
      .clock   (clock),
      .wr      (link_wr),
      .rd      (link_rd),
      .rd_data (link_rdata)
   );

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == REG_HEAP_LIMIT);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_HEAP_LIMIT) ? {15'd0, heap_limit_ff} : 32'd0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_addr_ff};

   // Size 0 falls into the smallest class.
   assign cls = (size_ff == 12'd0) ? '0 : CLS_BITS'((size_ff - 12'd1) >> GRAN_SHIFT);
   assign bytes = (WIDE_BITS'(cls) + WIDE_BITS'(1)) << GRAN_SHIFT;
   assign need  = WIDE_BITS'(bytes * REFILL_COUNT);
   assign left  = pool_end_ff - pool_start_ff;
   assign grow  = (need << 1) + (((heap_grown_ff >> 4) + WIDE_BITS'(GRANULE - 1))
                  & ~WIDE_BITS'(GRANULE - 1));
   assign limit = (heap_limit_ff > ADDR_SPACE) ? ADDR_SPACE : heap_limit_ff;
   assign left_cls = CLS_BITS'((left - WIDE_BITS'(1)) >> GRAN_SHIFT);
   assign next_addr = cur_ff + bytes;
   assign last_block = (count_ff == CNT_BITS'(REFILL_COUNT - 1)) || (rem_ff < bytes);
   assign head_rdata = heads_ff[head_ridx];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pool_start_ff <= '0;
         pool_end_ff   <= '0;
         heap_top_ff   <= TOP_RESET;
         heap_grown_ff <= '0;
         heap_limit_ff <= LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         pool_start_ff <= pool_start_in;
         pool_end_ff   <= pool_end_in;
         heap_top_ff   <= heap_top_in;
         heap_grown_ff <= heap_grown_in;
         heap_limit_ff <= heap_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (head_we) begin
            heads_ff[head_widx] <= head_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      tries_ff      <= tries_in;
      scan_ff       <= scan_in;
      cur_ff        <= cur_in;
      rem_ff        <= rem_in;
      count_ff      <= count_in;
      blk_ff        <= blk_in;
      status_ff     <= status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      pool_start_in = pool_start_ff;
      pool_end_in   = pool_end_ff;
      heap_top_in   = heap_top_ff;
      heap_grown_in = heap_grown_ff;
      heap_limit_in = cfg_write ? csr_pwdata[WIDE_BITS-1:0] : heap_limit_ff;
      tries_in      = tries_ff;
      scan_in       = scan_ff;
      cur_in        = cur_ff;
      rem_in        = rem_ff;
      count_in      = count_ff;
      blk_in        = blk_ff;
      status_in     = status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      head_ridx     = cls;
      head_we       = 1'b0;
      head_widx     = cls;
      head_wdata    = '0;
      link_wr       = '0;
      link_rd       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in   = req_tuser;
               size_in   = req_tdata[11:0];
               addr_in   = req_tdata[27:12];
               blk_in    = '0;
               status_in = STATUS_OK;
               tries_in  = '0;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (WIDE_BITS'(size_ff) > MAX_SMALL) begin
               status_in = STATUS_FORWARDED;
               state_in  = ST_RESP;
            end else if (kind_ff == KIND_RELEASE) begin
               if (addr_ff != '0) begin
                  link_wr    = '{en: 1'b1, slot: addr_ff[ADDR_BITS-1:GRAN_SHIFT],
                                 data: head_rdata};
                  head_we    = 1'b1;
                  head_wdata = addr_ff;
               end
               state_in = ST_RESP;
            end else if (head_rdata != '0) begin
               link_rd  = '{en: 1'b1, slot: head_rdata[ADDR_BITS-1:GRAN_SHIFT]};
               blk_in   = head_rdata;
               state_in = ST_POP_WAIT;
            end else begin
               state_in = ST_TRY;
            end
         end
         ST_POP_WAIT: begin
            head_we    = 1'b1;
            head_wdata = link_rdata;
            state_in   = ST_RESP;
         end
         ST_TRY: begin
            head_ridx = left_cls;
            if (tries_ff == 2'(TRY_LIMIT)) begin
               status_in = STATUS_NO_MEMORY;
               state_in  = ST_RESP;
            end else if (left >= bytes) begin
               blk_in = pool_start_ff[ADDR_BITS-1:0];
               if ((REFILL_COUNT > 1) && (left - bytes >= bytes)) begin
                  head_we    = 1'b1;
                  head_widx  = cls;
                  head_wdata = ADDR_BITS'(pool_start_ff + bytes);
                  cur_in     = pool_start_ff + bytes;
                  rem_in     = left - (bytes << 1);
                  count_in   = CNT_BITS'(1);
                  state_in   = ST_LINK;
               end else begin
                  if (pool_start_ff + bytes == pool_end_ff) begin
                     pool_start_in = '0;
                     pool_end_in   = '0;
                  end else begin
                     pool_start_in = pool_start_ff + bytes;
                  end
                  state_in = ST_RESP;
               end
            end else begin
               // The leftover is too small for this class; file it in its own class.
               if (left != '0) begin
                  link_wr    = '{en: 1'b1, slot: pool_start_ff[ADDR_BITS-1:GRAN_SHIFT],
                                 data: head_rdata};
                  head_we    = 1'b1;
                  head_widx  = left_cls;
                  head_wdata = pool_start_ff[ADDR_BITS-1:0];
               end
               pool_start_in = '0;
               pool_end_in   = '0;
               if ((heap_top_ff <= limit) && (grow <= limit - heap_top_ff)) begin
                  pool_start_in = heap_top_ff;
                  pool_end_in   = heap_top_ff + grow;
                  heap_top_in   = heap_top_ff + grow;
                  heap_grown_in = heap_grown_ff + grow;
                  tries_in      = tries_ff + 2'd1;
               end else begin
                  scan_in  = cls;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            head_ridx = scan_ff;
            if (head_rdata != '0) begin
               link_rd       = '{en: 1'b1, slot: head_rdata[ADDR_BITS-1:GRAN_SHIFT]};
               pool_start_in = WIDE_BITS'(head_rdata);
               pool_end_in   = WIDE_BITS'(head_rdata)
                               + ((WIDE_BITS'(scan_ff) + WIDE_BITS'(1)) << GRAN_SHIFT);
               state_in      = ST_SCAN_POP;
            end else if (scan_ff == CLS_BITS'(NUM_CLASSES - 1)) begin
               status_in = STATUS_NO_MEMORY;
               state_in  = ST_RESP;
            end else begin
               scan_in = scan_ff + CLS_BITS'(1);
            end
         end
         ST_SCAN_POP: begin
            head_we    = 1'b1;
            head_widx  = scan_ff;
            head_wdata = link_rdata;
            tries_in   = tries_ff + 2'd1;
            state_in   = ST_TRY;
         end
         ST_LINK: begin
            // Each refilled block points at the next one; the last one ends the list.
            link_wr = '{en: 1'b1, slot: cur_ff[ADDR_BITS-1:GRAN_SHIFT],
                        data: last_block ? '0 : next_addr[ADDR_BITS-1:0]};
            if (last_block) begin
               if (next_addr == pool_end_ff) begin
                  pool_start_in = '0;
                  pool_end_in   = '0;
               end else begin
                  pool_start_in = next_addr;
               end
               state_in = ST_RESP;
            end else begin
               cur_in   = next_addr;
               rem_in   = rem_ff - bytes;
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = blk_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SFLA_ASSERT_NOW(a_pool_ordered, 1'b1, pool_start_ff <= pool_end_ff)
   `SFLA_ASSERT_NOW(a_oom_null, rsp_valid_ff && (rsp_status_ff != STATUS_OK), rsp_addr_ff == '0)
   `SFLA_ASSERT_NEXT(a_busy_after_accept, req_accept, !req_tready)
   `SFLA_ASSERT_NOW(a_heap_bounded, 1'b1, heap_top_ff <= ADDR_SPACE)

endmodule

// ===== src/sfla_link_store.sv =====
// Link store: one next pointer per granule, one write and one registered read port.
module sfla_link_store
   import sfla_pkg::*;
(
   input  logic                 clock,
   input  link_wr_type          wr,
   input  link_rd_type          rd,
   output logic [ADDR_BITS-1:0] rd_data
);

   logic [ADDR_BITS-1:0] mem [LINK_DEPTH];
   logic [ADDR_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.slot] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.slot];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
